@@ src/kfc_pkg.sv @@
// ----------------------------------------------------------------------------
// KNX TP1 frame checker package
// Shared constants and the telegram record that flows from the front end
// through the result queue to the output stage.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int HEADER_BYTES        = 6;
  localparam int MAX_FRAME_BYTES_DEF = 23;
  localparam int HDR_STORE_BYTES     = 8;
  localparam int HDR_IDX_W           = $clog2(HDR_STORE_BYTES);
  localparam int POS_W               = 5;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] XOR_PRESET   = 8'hFF;
  localparam logic [7:0] LEN_MASK     = 8'b0000_1111;
  localparam logic [7:0] REPEAT_MASK  = 8'b0010_0000;
  localparam logic [7:0] GROUP_MASK   = 8'b1000_0000;
  localparam logic [7:0] ROUTING_MASK = 8'b0111_0000;
  localparam logic [7:0] COMM_MASK    = 8'b1100_0000;

  // Raw telegram bytes plus the checksum verdict, decoded at the output stage.
  typedef struct packed {
    logic       ok;
    logic [7:0] ctrl;
    logic [7:0] src_hi;
    logic [7:0] src_lo;
    logic [7:0] dst_hi;
    logic [7:0] dst_lo;
    logic [7:0] npci;
    logic [7:0] tpci;
    logic [7:0] apci;
  } frame_rec_t;

endpackage

@@ src/kfc_front.sv @@
// ----------------------------------------------------------------------------
// KNX TP1 frame checker front end
// Tracks the byte position, folds bytes into the running XOR, keeps the first
// eight bytes and emits one telegram record when the check byte arrives.
// ----------------------------------------------------------------------------
module kfc_front #(
  parameter int MAX_FRAME_BYTES = kfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                stall,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                rec_valid,
  output kfc_pkg::frame_rec_t rec
);

  localparam logic [kfc_pkg::POS_W-1:0] POS_MAX = kfc_pkg::POS_W'(MAX_FRAME_BYTES);
  localparam logic [kfc_pkg::POS_W-1:0] POS_HDR_LAST = kfc_pkg::POS_W'(kfc_pkg::HEADER_BYTES - 1);
  localparam logic [kfc_pkg::POS_W-1:0] POS_CHECK_BASE =
    kfc_pkg::POS_W'(kfc_pkg::HEADER_BYTES + 1);

  logic [kfc_pkg::POS_W-1:0] pos;
  logic [kfc_pkg::POS_W-1:0] pos_next;
  logic [7:0]                run_xor;
  logic [7:0]                run_xor_next;
  logic                      active;
  logic                      active_next;
  logic [7:0]                hdr [kfc_pkg::HDR_STORE_BYTES];

  logic [kfc_pkg::POS_W-1:0] pos_eff;
  logic [7:0]                xor_eff;
  logic                      active_eff;
  logic [kfc_pkg::POS_W-1:0] check_pos;
  logic                      take;
  logic                      is_over;
  logic                      is_check;
  logic                      hdr_we;

  always_comb begin
    take       = push && !stall;
    pos_eff    = frame_start ? '0 : pos;
    xor_eff    = frame_start ? kfc_pkg::XOR_PRESET : run_xor;
    active_eff = frame_start || active;
    check_pos  = POS_CHECK_BASE + {1'b0, hdr[5][3:0]};
    is_over    = pos_eff >= POS_MAX;
    is_check   = (pos_eff > POS_HDR_LAST) && (pos_eff == check_pos);

    pos_next     = pos;
    run_xor_next = run_xor;
    active_next  = active;
    hdr_we       = 1'b0;
    rec_valid    = 1'b0;
    if (take && active_eff) begin
      if (is_over) begin
        // Telegram ran past the longest allowed length: drop it silently.
        active_next  = 1'b0;
        pos_next     = pos_eff;
        run_xor_next = xor_eff;
      end else if (is_check) begin
        active_next = 1'b0;
        rec_valid   = 1'b1;
      end else begin
        hdr_we       = 1'b1;
        active_next  = 1'b1;
        run_xor_next = xor_eff ^ data_byte;
        pos_next     = pos_eff + 1'b1;
      end
    end

    rec.ok     = (data_byte == xor_eff);
    rec.ctrl   = hdr[0];
    rec.src_hi = hdr[1];
    rec.src_lo = hdr[2];
    rec.dst_hi = hdr[3];
    rec.dst_lo = hdr[4];
    rec.npci   = hdr[5];
    rec.tpci   = hdr[6];
    rec.apci   = hdr[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      run_xor <= kfc_pkg::XOR_PRESET;
      active  <= 1'b0;
    end else begin
      pos     <= pos_next;
      run_xor <= run_xor_next;
      active  <= active_next;
    end
  end

  // Only the first eight bytes of a telegram are kept.
  always_ff @(posedge clk) begin
    if (hdr_we && (pos_eff[kfc_pkg::POS_W-1:kfc_pkg::HDR_IDX_W] == '0)) begin
      hdr[pos_eff[kfc_pkg::HDR_IDX_W-1:0]] <= data_byte;
    end
  end

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    rec_valid |=> !active)
    else $error("telegram still open after its check byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_MAX)
    else $error("byte position beyond the longest telegram");

endmodule

@@ src/kfc_queue.sv @@
// ----------------------------------------------------------------------------
// KNX TP1 frame checker result queue
// Short register queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module kfc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  kfc_pkg::frame_rec_t wr_rec,
  input  logic                rd_en,
  output kfc_pkg::frame_rec_t rd_rec,
  output logic                not_empty,
  output logic                full
);

  localparam logic [kfc_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
    kfc_pkg::QUEUE_CNT_W'(kfc_pkg::QUEUE_DEPTH);

  kfc_pkg::frame_rec_t             mem [kfc_pkg::QUEUE_DEPTH];
  logic [kfc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [kfc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [kfc_pkg::QUEUE_CNT_W-1:0] count;
  logic                            do_rd;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_rd     = rd_en && not_empty;
  assign rd_rec    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr_en && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("result queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("result queue count out of range");

endmodule

@@ src/kfc_back.sv @@
// ----------------------------------------------------------------------------
// KNX TP1 frame checker output stage
// Takes the oldest telegram record from the queue, decodes the header fields
// and holds them until the word is popped.
// ----------------------------------------------------------------------------
module kfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  kfc_pkg::frame_rec_t q_rec,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic                checksum_ok,
  output logic                repeated,
  output logic [1:0]          priority_res,
  output logic [15:0]         source_address,
  output logic                target_is_group,
  output logic [15:0]         target_address,
  output logic [2:0]          routing_counter,
  output logic [4:0]          payload_length,
  output logic [1:0]          communication_type,
  output logic [3:0]          sequence_number,
  output logic [3:0]          command,
  output logic [5:0]          first_data
);

  logic       out_valid;
  logic       load;
  logic [7:0] apci_eff;

  assign empty = !out_valid;
  assign load  = q_not_empty && (!out_valid || pop);
  assign q_rd  = load;

  // With a one-byte payload the byte after the TPCI byte is the check byte.
  assign apci_eff = ((q_rec.npci & kfc_pkg::LEN_MASK) != '0) ? q_rec.apci : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      checksum_ok        <= q_rec.ok;
      repeated           <= (q_rec.ctrl & kfc_pkg::REPEAT_MASK) == '0;
      priority_res       <= q_rec.ctrl[3:2];
      source_address     <= {q_rec.src_hi, q_rec.src_lo};
      target_is_group    <= (q_rec.npci & kfc_pkg::GROUP_MASK) != '0;
      target_address     <= {q_rec.dst_hi, q_rec.dst_lo};
      routing_counter    <= q_rec.npci[6:4];
      payload_length     <= {1'b0, q_rec.npci[3:0]} + 5'd1;
      communication_type <= q_rec.tpci[7:6];
      sequence_number    <= q_rec.tpci[5:2];
      command            <= {q_rec.tpci[1:0], apci_eff[7:6]};
      first_data         <= apci_eff[5:0];
    end
  end

  a_load_from_queue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(source_address)
                             && $stable(checksum_ok)))
    else $error("waiting result word changed before it was popped");

endmodule

@@ src/knx_tp_frame_checker.sv @@
// ----------------------------------------------------------------------------
// KNX TP1 telegram frame checker
// Checks the XOR checksum of each telegram and decodes its header fields.
//
//   Channel  Direction  Handshake          Payload
//   input    in         push / full        data_byte, frame_start
//   result   out        empty / pop        checksum_ok and decoded header
//
// One byte is taken every cycle while the result queue has room.
// A telegram result is written into the result queue when its check byte is
// taken, then moves into the output register once that is empty or popped.
// full rises only when both queue entries hold results; with the output
// register that gives three waiting results before input stalls.
// Reset (rst, synchronous) closes any open telegram and empties all stages.
// ----------------------------------------------------------------------------
module knx_tp_frame_checker #(
  parameter int MAX_FRAME_BYTES = kfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        empty,
  input  logic        pop,
  output logic        checksum_ok,
  output logic        repeated,
  output logic [1:0]  priority_res,
  output logic [15:0] source_address,
  output logic        target_is_group,
  output logic [15:0] target_address,
  output logic [2:0]  routing_counter,
  output logic [4:0]  payload_length,
  output logic [1:0]  communication_type,
  output logic [3:0]  sequence_number,
  output logic [3:0]  command,
  output logic [5:0]  first_data
);

  kfc_pkg::frame_rec_t front_rec;
  kfc_pkg::frame_rec_t q_rec;
  logic                front_valid;
  logic                q_full;
  logic                q_not_empty;
  logic                q_rd;

  assign full = q_full;

  kfc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .stall      (q_full),
    .data_byte  (data_byte),
    .frame_start(frame_start),
    .rec_valid  (front_valid),
    .rec        (front_rec)
  );

  kfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_rec   (front_rec),
    .rd_en    (q_rd),
    .rd_rec   (q_rec),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  kfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_not_empty       (q_not_empty),
    .q_rec             (q_rec),
    .q_rd              (q_rd),
    .pop               (pop),
    .empty             (empty),
    .checksum_ok       (checksum_ok),
    .repeated          (repeated),
    .priority_res      (priority_res),
    .source_address    (source_address),
    .target_is_group   (target_is_group),
    .target_address    (target_address),
    .routing_counter   (routing_counter),
    .payload_length    (payload_length),
    .communication_type(communication_type),
    .sequence_number   (sequence_number),
    .command           (command),
    .first_data        (first_data)
  );

endmodule

@@ tb/knx_tp_frame_checker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// KNX TP1 frame checker testbench
// Feeds telegram bytes through the push/full side and checks every decoded
// result word on the empty/pop side against an in-bench telegram decoder.
// Runs a short directed set, then random telegrams under four idle/stall mixes.
// ----------------------------------------------------------------------------
module knx_tp_frame_checker_tb;

  typedef struct packed {
    logic        checksum_ok;
    logic        repeated;
    logic [1:0]  priority_res;
    logic [15:0] source_address;
    logic        target_is_group;
    logic [15:0] target_address;
    logic [2:0]  routing_counter;
    logic [4:0]  payload_length;
    logic [1:0]  communication_type;
    logic [3:0]  sequence_number;
    logic [3:0]  command;
    logic [5:0]  first_data;
  } telegram_t;

  // Tracks the telegram being received and holds the decoded results still owed.
  class telegram_ledger;
    logic [4:0] position;
    logic [7:0] parity;
    logic [7:0] header [kfc_pkg::HDR_STORE_BYTES];
    bit         in_frame;
    telegram_t  awaited [$];
    int         mismatches;
    int         telegrams_checked;
    int         bad_sums_sent;

    function new();
      position = '0;
      parity = kfc_pkg::XOR_PRESET;
      in_frame = 1'b0;
      foreach (header[i]) header[i] = '0;
      mismatches = 0;
      telegrams_checked = 0;
      bad_sums_sent = 0;
    endfunction

    // Returns 1 when the byte was taken into a telegram, 0 when it was ignored.
    function bit take_byte(logic [7:0] b, logic start);
      telegram_t  t;
      logic [7:0] b7;
      int         check_at;
      if (start) begin
        position = '0;
        parity = kfc_pkg::XOR_PRESET;
        in_frame = 1'b1;
      end
      if (!in_frame) return 1'b0;
      if (position >= kfc_pkg::MAX_FRAME_BYTES_DEF) begin
        in_frame = 1'b0;
        return 1'b0;
      end
      if (position >= kfc_pkg::HEADER_BYTES) begin
        check_at = kfc_pkg::HEADER_BYTES + int'(header[5] & kfc_pkg::LEN_MASK) + 1;
        if (int'(position) == check_at) begin
          // With a one-byte payload byte 7 is the check byte itself.
          b7 = (header[5][3:0] != 4'd0) ? header[7] : 8'h00;
          t.checksum_ok = (b == parity);
          t.repeated = ((header[0] & kfc_pkg::REPEAT_MASK) == 8'h00);
          t.priority_res = header[0][3:2];
          t.source_address = {header[1], header[2]};
          t.target_is_group = ((header[5] & kfc_pkg::GROUP_MASK) != 8'h00);
          t.target_address = {header[3], header[4]};
          t.routing_counter = 3'((header[5] & kfc_pkg::ROUTING_MASK) >> 4);
          t.payload_length = {1'b0, header[5][3:0]} + 5'd1;
          t.communication_type = 2'((header[6] & kfc_pkg::COMM_MASK) >> 6);
          t.sequence_number = header[6][5:2];
          t.command = {header[6][1:0], b7[7:6]};
          t.first_data = b7[5:0];
          if (!t.checksum_ok) bad_sums_sent++;
          awaited.push_back(t);
          in_frame = 1'b0;
          return 1'b1;
        end
      end
      if (position < kfc_pkg::HDR_STORE_BYTES) header[position[2:0]] = b;
      parity ^= b;
      position += 5'd1;
      return 1'b1;
    endfunction

    function void field_check(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_telegram(telegram_t got);
      telegram_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word 0x%0h arrived with none pending", $time, got);
        return;
      end
      want = awaited.pop_front();
      telegrams_checked++;
      field_check("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
      field_check("repeated", 32'(want.repeated), 32'(got.repeated));
      field_check("priority_res", 32'(want.priority_res), 32'(got.priority_res));
      field_check("source_address", 32'(want.source_address), 32'(got.source_address));
      field_check("target_is_group", 32'(want.target_is_group), 32'(got.target_is_group));
      field_check("target_address", 32'(want.target_address), 32'(got.target_address));
      field_check("routing_counter", 32'(want.routing_counter), 32'(got.routing_counter));
      field_check("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      field_check("communication_type", 32'(want.communication_type),
                  32'(got.communication_type));
      field_check("sequence_number", 32'(want.sequence_number), 32'(got.sequence_number));
      field_check("command", 32'(want.command), 32'(got.command));
      field_check("first_data", 32'(want.first_data), 32'(got.first_data));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        empty;
  logic        pop;
  logic        checksum_ok;
  logic        repeated;
  logic [1:0]  priority_res;
  logic [15:0] source_address;
  logic        target_is_group;
  logic [15:0] target_address;
  logic [2:0]  routing_counter;
  logic [4:0]  payload_length;
  logic [1:0]  communication_type;
  logic [3:0]  sequence_number;
  logic [3:0]  command;
  logic [5:0]  first_data;

  telegram_ledger ledger;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int sent_bytes;
  int taken_bytes;
  int full_cycles;

  knx_tp_frame_checker DUT (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .data_byte          (data_byte),
    .frame_start        (frame_start),
    .empty              (empty),
    .pop                (pop),
    .checksum_ok        (checksum_ok),
    .repeated           (repeated),
    .priority_res       (priority_res),
    .source_address     (source_address),
    .target_is_group    (target_is_group),
    .target_address     (target_address),
    .routing_counter    (routing_counter),
    .payload_length     (payload_length),
    .communication_type (communication_type),
    .sequence_number    (sequence_number),
    .command            (command),
    .first_data         (first_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Timed out with %0d result words still pending", ledger.awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one input word, with optional idle cycles first, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    frame_start <= start;
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    sent_bytes++;
    if (ledger.take_byte(b, start)) taken_bytes++;
  endtask

  // Header bytes 0..4 come from head; byte 5 keeps its high nibble and carries the
  // length. A negative fill gives random payload bytes.
  task automatic send_telegram(input logic [47:0] head, input int plen, input int fill,
                               input bit corrupt);
    logic [7:0] b;
    logic [7:0] sum;
    sum = kfc_pkg::XOR_PRESET;
    for (int i = 0; i < kfc_pkg::HEADER_BYTES + plen; i++) begin
      if (i < 5) b = head[47 - 8 * i -: 8];
      else if (i == 5) b = {head[7:4], 4'(plen - 1)};
      else if (fill < 0) b = 8'($urandom);
      else b = fill[7:0];
      send_byte(b, i == 0);
      sum ^= b;
    end
    if (corrupt) sum ^= 8'(1 << $urandom_range(7));
    send_byte(sum, 1'b0);
  endtask

  task automatic run_phase(input int quota);
    int stop_at;
    int pick;
    int n;
    int plen;
    stop_at = taken_bytes + quota;
    send_telegram(48'({$urandom, $urandom}), 16, -1, 1'b0);
    while (taken_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        plen = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
        send_telegram(48'({$urandom, $urandom}), plen, -1, $urandom_range(3) == 0);
      end else if (pick < 85) begin
        // A telegram cut short; the next start drops it.
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), i == 0);
      end else if (pick < 95) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin : result_side
    telegram_t got;
    int        hold_left;
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {checksum_ok, repeated, priority_res, source_address, target_is_group,
               target_address, routing_counter, payload_length, communication_type,
               sequence_number, command, first_data};
        ledger.check_telegram(got);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    ledger = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    sent_bytes = 0;
    taken_bytes = 0;
    full_cycles = 0;
    rst = 1'b1;
    push = 1'b0;
    data_byte = 8'h00;
    frame_start = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray byte, all-ones telegram with a one-byte payload, a byte after
    // the check byte, a restart in mid-telegram, then all zeros with a bad check.
    send_byte(8'h5A, 1'b0);
    send_telegram(48'hFFFF_FFFF_FFFF, 1, 255, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hBC, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_telegram(48'h0, 2, 0, 1'b1);
    send_byte(8'hFF, 1'b0);

    // The receiver stalls for a long stretch here so the block fills and pushes back.
    hold_req = 400;
    run_phase(250);
    send_idle_pct = 51;
    run_phase(250);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    run_phase(250);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    run_phase(250);
    push <= 1'b0;
    recv_stall_pct = 0;

    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Offered %0d bytes, %0d taken into telegrams; %0d results checked, %0d bad checks.",
             sent_bytes, taken_bytes, ledger.telegrams_checked, ledger.bad_sums_sent);
    $display("Input was held off by a full block for %0d cycles; %0d field mismatches.",
             full_cycles, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
